[rtl/core/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and constants shared by the stable priority queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int TAG_W         = 16;
  localparam int BASE_W        = 8;
  localparam int PRIO_W        = 9;
  localparam int CNT_W         = 9;
  localparam int MODE_W        = 2;
  localparam int STATUS_W      = 2;

  localparam logic [PRIO_W-1:0] NORMAL_BOOST = PRIO_W'(120);

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic              do_insert;
    logic              do_remove;
    entry_t            new_entry;
    logic [CNT_W-1:0]  count;
  } cell_ctl_t;

endpackage

[rtl/core/stable_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Bounded priority queue held as a chain of sorted cells, head in cell 0.
// Equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  input    | start & !busy        | in_mode, in_process_tag,
//           |                      | in_base_priority, in_is_normal
//  result   | out_valid (1 cycle)  | out_head_tag, out_head_priority,
//           |                      | out_head_valid, out_entry_count,
//           |                      | out_status
//
//  One transaction per cycle; busy stays low. Every cell updates in the
//  same cycle, so the chain compare and shift never holds back the input.
//  The result appears on the cycle after acceptance, for one cycle.
//  Reset empties the queue; the receiver cannot stall the result.
// ----------------------------------------------------------------------------
module stable_priority_queue_core #(
  parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [spq_pkg::MODE_W-1:0]   in_mode,
  input  logic [spq_pkg::TAG_W-1:0]    in_process_tag,
  input  logic [spq_pkg::BASE_W-1:0]   in_base_priority,
  input  logic                         in_is_normal,
  output logic                         out_valid,
  output logic [spq_pkg::TAG_W-1:0]    out_head_tag,
  output logic [spq_pkg::PRIO_W-1:0]   out_head_priority,
  output logic                         out_head_valid,
  output logic [spq_pkg::CNT_W-1:0]    out_entry_count,
  output logic [spq_pkg::STATUS_W-1:0] out_status
);
  import spq_pkg::*;

  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r;
  entry_t              head_r, head_nxt;
  logic                head_valid_r, head_valid_nxt;
  logic [CNT_W-1:0]    out_count_r;
  status_t             status_r, status_nxt;

  logic                accept;
  logic                empty, full;
  mode_t               mode;
  entry_t              new_entry;
  cell_ctl_t           ctl;
  logic   [QUEUE_DEPTH-1:0] take;
  entry_t [QUEUE_DEPTH-1:0] cells;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign mode   = mode_t'(in_mode);
  assign empty  = count_r == '0;
  assign full   = count_r == CNT_W'(QUEUE_DEPTH);

  assign new_entry.tag  = in_process_tag;
  assign new_entry.prio = PRIO_W'(in_base_priority) + (in_is_normal ? NORMAL_BOOST : '0);

  assign ctl.do_insert = accept && (mode == MODE_INSERT) && !full;
  assign ctl.do_remove = accept && (mode == MODE_REMOVE) && !empty;
  assign ctl.new_entry = new_entry;
  assign ctl.count     = count_r;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_cell #(.IDX(i)) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .left_take   ((i == 0) ? 1'b0 : take[(i == 0) ? 0 : i - 1]),
      .left_entry  (cells[(i == 0) ? 0 : i - 1]),
      .right_entry (cells[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .take        (take[i]),
      .entry       (cells[i])
    );
  end

  always_comb begin
    count_nxt      = count_r;
    head_nxt       = '0;
    head_valid_nxt = 1'b0;
    status_nxt     = ST_OK;
    unique case (mode)
      MODE_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      MODE_REMOVE, MODE_PEEK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          head_nxt       = cells[0];
          head_valid_nxt = 1'b1;
          if (mode == MODE_REMOVE) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      MODE_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_r       <= head_nxt;
      head_valid_r <= head_valid_nxt;
      out_count_r  <= count_nxt;
      status_r     <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_head_tag      = head_r.tag;
  assign out_head_priority = head_r.prio;
  assign out_head_valid    = head_valid_r;
  assign out_entry_count   = out_count_r;
  assign out_status        = status_r;

endmodule

[rtl/core/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. Decides locally whether the new entry or
// its left neighbor moves in on insert, and takes its right neighbor on
// remove.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               left_take,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output logic               take,
  output spq_pkg::entry_t    entry
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   occupied;

  assign occupied = CNT_W'(IDX) < ctl.count;
  assign take     = occupied ? (entry_r.prio > ctl.new_entry.prio)
                             : (CNT_W'(IDX) == ctl.count);
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctl.do_insert && take) begin
      entry_nxt = left_take ? left_entry : ctl.new_entry;
    end else if (ctl.do_remove) begin
      entry_nxt = right_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[rtl/core/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the stable priority queue core, bound into each instance of the core.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic                         out_head_valid,
  input logic [spq_pkg::CNT_W-1:0]    out_entry_count,
  input logic [spq_pkg::STATUS_W-1:0] out_status
);
  import spq_pkg::*;

  // every accepted transaction yields a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("missing result after accepted transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without transaction");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CNT_W'(QUEUE_DEPTH)))
    else $error("entry count beyond depth");

  a_head_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_head_valid) |-> (out_status == ST_OK))
    else $error("head reported with error status");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |->
      (out_entry_count == CNT_W'(QUEUE_DEPTH)) && !out_head_valid)
    else $error("full status with room left");

endmodule

bind stable_priority_queue_core spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_head_valid  (out_head_valid),
  .out_entry_count (out_entry_count),
  .out_status      (out_status)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stable_priority_queue_core. A directed table covers
// the empty, full, clear and equal-priority cases; a long random run with
// fill/drain phases follows. Each result is checked against the row's pinned
// report or a sorted-list model of the queue held in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import spq_pkg::*;

  localparam int QDEPTH     = DEFAULT_DEPTH;
  localparam int RAND_ITEMS = 1410;
  localparam int STALL_MAX  = 4000;
  localparam int DIR_ROWS_N = 21;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic              hv;
    logic [CNT_W-1:0]  cnt;
    status_t           st;
  } head_report_t;

  typedef struct packed {
    mode_t             m;
    logic [TAG_W-1:0]  tag;
    logic [BASE_W-1:0] base;
    logic              nrm;
    logic [4:0]        reps;
    logic              pinned;
    head_report_t      pin;
  } stim_row_t;

  localparam head_report_t NO_PIN = '{16'h0, 9'd0, 1'b0, 9'd0, ST_OK};

  localparam stim_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{MODE_REMOVE, 16'h0000, 8'h00, 1'b0, 5'd1, 1'b1, '{16'h0, 9'd0, 1'b0, 9'd0, ST_EMPTY}},
    '{MODE_PEEK,   16'h0000, 8'h00, 1'b0, 5'd1, 1'b1, '{16'h0, 9'd0, 1'b0, 9'd0, ST_EMPTY}},
    '{MODE_CLEAR,  16'h0000, 8'h00, 1'b0, 5'd1, 1'b1, '{16'h0, 9'd0, 1'b0, 9'd0, ST_OK}},
    '{MODE_INSERT, 16'hffff, 8'hff, 1'b1, 5'd1, 1'b1, '{16'h0, 9'd0, 1'b0, 9'd1, ST_OK}},
    '{MODE_PEEK,   16'h0000, 8'h00, 1'b0, 5'd1, 1'b1,
      '{16'hffff, 9'd375, 1'b1, 9'd1, ST_OK}},
    '{MODE_INSERT, 16'h0000, 8'h00, 1'b0, 5'd1, 1'b1, '{16'h0, 9'd0, 1'b0, 9'd2, ST_OK}},
    '{MODE_PEEK,   16'hffff, 8'hff, 1'b1, 5'd1, 1'b1, '{16'h0, 9'd0, 1'b1, 9'd2, ST_OK}},
    '{MODE_REMOVE, 16'h0000, 8'h00, 1'b0, 5'd1, 1'b1, '{16'h0, 9'd0, 1'b1, 9'd1, ST_OK}},
    '{MODE_REMOVE, 16'h0000, 8'h00, 1'b0, 5'd1, 1'b1,
      '{16'hffff, 9'd375, 1'b1, 9'd0, ST_OK}},
    '{MODE_INSERT, 16'h1111, 8'd120, 1'b0, 5'd1, 1'b1, '{16'h0, 9'd0, 1'b0, 9'd1, ST_OK}},
    '{MODE_INSERT, 16'h2222, 8'd0, 1'b1, 5'd1, 1'b1, '{16'h0, 9'd0, 1'b0, 9'd2, ST_OK}},
    '{MODE_REMOVE, 16'h0000, 8'h00, 1'b0, 5'd1, 1'b1,
      '{16'h1111, 9'd120, 1'b1, 9'd1, ST_OK}},
    '{MODE_REMOVE, 16'h0000, 8'h00, 1'b0, 5'd1, 1'b1,
      '{16'h2222, 9'd120, 1'b1, 9'd0, ST_OK}},
    '{MODE_INSERT, 16'ha500, 8'h5a, 1'b1, 5'd16, 1'b0, NO_PIN},
    '{MODE_INSERT, 16'h5aff, 8'h00, 1'b0, 5'd1, 1'b1, '{16'h0, 9'd0, 1'b0, 9'd16, ST_FULL}},
    '{MODE_PEEK,   16'h0000, 8'h00, 1'b0, 5'd1, 1'b1,
      '{16'ha500, 9'd210, 1'b1, 9'd16, ST_OK}},
    '{MODE_REMOVE, 16'h0000, 8'h00, 1'b0, 5'd3, 1'b0, NO_PIN},
    '{MODE_INSERT, 16'h0f0f, 8'ha5, 1'b0, 5'd3, 1'b0, NO_PIN},
    '{MODE_CLEAR,  16'h0000, 8'h00, 1'b0, 5'd1, 1'b1, '{16'h0, 9'd0, 1'b0, 9'd0, ST_OK}},
    '{MODE_REMOVE, 16'h0000, 8'h00, 1'b0, 5'd1, 1'b1, '{16'h0, 9'd0, 1'b0, 9'd0, ST_EMPTY}},
    '{MODE_INSERT, 16'h1234, 8'h80, 1'b1, 5'd2, 1'b0, NO_PIN}
  };

  logic                clk;
  logic                rst_n            = 1'b0;
  logic                start            = 1'b0;
  logic                busy;
  mode_t               in_mode          = MODE_INSERT;
  logic [TAG_W-1:0]    in_process_tag   = '0;
  logic [BASE_W-1:0]   in_base_priority = '0;
  logic                in_is_normal     = 1'b0;
  logic                out_valid;
  logic [TAG_W-1:0]    out_head_tag;
  logic [PRIO_W-1:0]   out_head_priority;
  logic                out_head_valid;
  logic [CNT_W-1:0]    out_entry_count;
  logic [STATUS_W-1:0] out_status;

  entry_t       sorted_entries [QDEPTH];
  int           held_entries = 0;
  head_report_t pending_heads [$];

  int idle_pct    = 0;
  int mismatches  = 0;
  int sent        = 0;
  int checked     = 0;
  int full_drops  = 0;
  int empty_hits  = 0;
  int peak_count  = 0;
  int stall_count = 0;

  stable_priority_queue_core #(.QUEUE_DEPTH(QDEPTH)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_process_tag    (in_process_tag),
    .in_base_priority  (in_base_priority),
    .in_is_normal      (in_is_normal),
    .out_valid         (out_valid),
    .out_head_tag      (out_head_tag),
    .out_head_priority (out_head_priority),
    .out_head_valid    (out_head_valid),
    .out_entry_count   (out_entry_count),
    .out_status        (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sorted-list queue model: apply one operation, return the head report.
  function automatic head_report_t queue_apply(mode_t m, logic [TAG_W-1:0] tag,
                                               logic [BASE_W-1:0] base, logic nrm);
    head_report_t rep;
    logic [PRIO_W-1:0] prio;
    int pos;
    rep = '{16'h0, 9'd0, 1'b0, 9'd0, ST_OK};
    case (m)
      MODE_INSERT: begin
        prio = {1'b0, base} + (nrm ? NORMAL_BOOST : '0);
        if (held_entries >= QDEPTH) begin
          rep.st = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_entries && sorted_entries[pos].prio <= prio) pos++;
          for (int i = held_entries; i > pos; i--) sorted_entries[i] = sorted_entries[i-1];
          sorted_entries[pos] = '{tag, prio};
          held_entries++;
        end
      end
      MODE_REMOVE, MODE_PEEK: begin
        if (held_entries == 0) begin
          rep.st = ST_EMPTY;
        end else begin
          rep.tag  = sorted_entries[0].tag;
          rep.prio = sorted_entries[0].prio;
          rep.hv   = 1'b1;
          if (m == MODE_REMOVE) begin
            for (int i = 1; i < held_entries; i++) sorted_entries[i-1] = sorted_entries[i];
            held_entries--;
          end
        end
      end
      default: held_entries = 0;
    endcase
    rep.cnt = CNT_W'(held_entries);
    return rep;
  endfunction

  // Called just after a rising edge; returns at the edge that accepts the transaction.
  task automatic send_op(input mode_t m, input logic [TAG_W-1:0] tag,
                         input logic [BASE_W-1:0] base, input logic nrm,
                         input logic pinned, input head_report_t pin);
    head_report_t model_rep;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    in_mode          <= m;
    in_process_tag   <= tag;
    in_base_priority <= base;
    in_is_normal     <= nrm;
    @(posedge clk);
    while (busy) @(posedge clk);
    model_rep = queue_apply(m, tag, base, nrm);
    pending_heads.push_back(pinned ? pin : model_rep);
    sent++;
    if (held_entries > peak_count) peak_count = held_entries;
  endtask

  always @(posedge clk) begin
    head_report_t want;
    head_report_t seen;
    if (rst_n && out_valid) begin
      seen = '{out_head_tag, out_head_priority, out_head_valid, out_entry_count,
               status_t'(out_status)};
      if (pending_heads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result tag=%h prio=%0d hv=%b cnt=%0d st=%0d",
                   $time, seen.tag, seen.prio, seen.hv, seen.cnt, seen.st);
      end else begin
        want = pending_heads.pop_front();
        checked++;
        if (want.st == ST_FULL) full_drops++;
        if (want.st == ST_EMPTY) empty_hits++;
        if (seen.tag !== want.tag || seen.prio !== want.prio || seen.hv !== want.hv ||
            seen.cnt !== want.cnt || seen.st !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result %0d: exp tag=%h prio=%0d hv=%b cnt=%0d st=%0d, %s",
                     $time, checked, want.tag, want.prio, want.hv, want.cnt, want.st,
                     $sformatf("got tag=%h prio=%0d hv=%b cnt=%0d st=%0d",
                               seen.tag, seen.prio, seen.hv, seen.cnt, seen.st));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= STALL_MAX) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, STALL_MAX);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    mode_t             m;
    logic [BASE_W-1:0] base;
    int                fill_bias;
    int                r;
    fill_bias = 50;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 14;
    foreach (DIR_ROWS[k]) begin
      for (int rep = 0; rep < DIR_ROWS[k].reps; rep++)
        send_op(DIR_ROWS[k].m, DIR_ROWS[k].tag + TAG_W'(rep), DIR_ROWS[k].base,
                DIR_ROWS[k].nrm, DIR_ROWS[k].pinned, DIR_ROWS[k].pin);
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i < RAND_ITEMS / 3) idle_pct = 14;
      else if (i < 2 * RAND_ITEMS / 3) idle_pct = 57;
      else idle_pct = 0;
      // switch at random between fill-heavy and drain-heavy stretches to hit full and empty
      if (i % 40 == 0) fill_bias = $urandom_range(1) ? 75 : 30;
      r = $urandom_range(99);
      if (r < 3) m = MODE_CLEAR;
      else if (r < fill_bias) m = MODE_INSERT;
      else m = ($urandom_range(2) == 2) ? MODE_PEEK : MODE_REMOVE;
      case ($urandom_range(3))
        0:       base = BASE_W'($urandom_range(7));
        1:       base = BASE_W'(120 + $urandom_range(7));
        default: base = BASE_W'($urandom);
      endcase
      send_op(m, TAG_W'($urandom), base, 1'($urandom), 1'b0, NO_PIN);
    end
    start <= 1'b0;

    while (pending_heads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Ran %0d transactions, %0d results checked, %0d mismatches.",
             sent, checked, mismatches);
    $display("Full-queue drops %0d, empty remove/peek %0d, peak occupancy %0d of %0d.",
             full_drops, empty_hits, peak_count, QDEPTH);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
